/* sv/ibe_pkg.sv */
`timescale 1ns / 1ps

package ibe_pkg;

  localparam logic [1:0] OP_EFFORT      = 2'd0;
  localparam logic [1:0] OP_WRITE_LOWER = 2'd1;
  localparam logic [1:0] OP_WRITE_UPPER = 2'd2;

  localparam logic [1:0] REG_X_MINIMUM   = 2'd0;
  localparam logic [1:0] REG_X_MAXIMUM   = 2'd1;
  localparam logic [1:0] REG_INDEX_SCALE = 2'd2;

  localparam logic [16:0] FRAC_ONE = 17'd65536;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] altitude;
    logic signed [31:0] velocity;
    logic [5:0]         entry_index;
    logic signed [31:0] entry_value;
  } item_t;

  typedef struct packed {
    logic [16:0]        effort;
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
  } result_t;

endpackage

/* sv/interpolated_bounds_effort_unit.sv */
`timescale 1ns / 1ps

// Piecewise linear bounds lookup with normalised effort. Two tables of
// TABLE_SIZE Q16.16 entries hold the lower and upper bound versus altitude;
// ops 1 and 2 load one entry each and give no result, op 0 locates the
// altitude in the table range (x_minimum, x_maximum, index_scale), interpolates
// both bounds and returns effort = (velocity - lower) / (upper - lower)
// clamped to [0, 65536] in Q1.16, together with both bounds. The unit takes
// one item every clock cycle unless a held result is stalled; effort results
// pass through the 16-stage radix-2 divider, one quotient bit per stage. Table
// entries are undefined until written. The user must write the configuration
// registers only while the unit holds no item; the unit does not enforce this.
module interpolated_bounds_effort_unit #(
  parameter int TABLE_SIZE = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  ibe_pkg::item_t     item,
  output logic               result_valid,
  input  logic               result_stall,
  output ibe_pkg::result_t   result
);

  localparam int IDXW = $clog2(TABLE_SIZE);
  localparam int DIV_STEPS = 16;

  // divider stage contents
  typedef struct packed {
    logic        valid;
    logic        fixed;
    logic [16:0] eff_fixed;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] den;
    logic [31:0] rem;
    logic [15:0] q;
  } div_t;

  // configuration registers
  logic signed [31:0] x_minimum;
  logic signed [31:0] x_maximum;
  logic [31:0]        index_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_minimum   <= '0;
      x_maximum   <= '0;
      index_scale <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ibe_pkg::REG_X_MINIMUM:   x_minimum   <= cfg_data;
        ibe_pkg::REG_X_MAXIMUM:   x_maximum   <= cfg_data;
        ibe_pkg::REG_INDEX_SCALE: index_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // the whole pipeline moves together unless a held result is stalled
  logic adv;
  assign adv        = !(result_valid && result_stall);
  assign item_stall = !adv;

  // stage 0: capture, range classification, offset from x_minimum
  logic               s0_valid, s0_calc, s0_write, s0_upper;
  logic               s0_below, s0_above;
  logic [31:0]        s0_dist;
  logic signed [31:0] s0_vel;
  logic [IDXW-1:0]    s0_widx;
  logic [31:0]        s0_wval;
  logic [32:0]        dist_full;

  assign dist_full = {item.altitude[31], item.altitude} - {x_minimum[31], x_minimum};

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_calc  <= item.op == ibe_pkg::OP_EFFORT;
      s0_write <= (item.op == ibe_pkg::OP_WRITE_LOWER || item.op == ibe_pkg::OP_WRITE_UPPER)
                  && (32'(item.entry_index) < 32'(TABLE_SIZE));
      s0_upper <= item.op == ibe_pkg::OP_WRITE_UPPER;
      s0_below <= item.altitude < x_minimum;
      s0_above <= item.altitude > x_maximum;
      s0_dist  <= dist_full[31:0];
      s0_vel   <= item.velocity;
      s0_widx  <= IDXW'(item.entry_index);
      s0_wval  <= item.entry_value;
    end
  end

  // stage 1: position product
  logic               s1_valid, s1_calc, s1_write, s1_upper, s1_below, s1_above;
  logic [63:0]        s1_prod;
  logic signed [31:0] s1_vel;
  logic [IDXW-1:0]    s1_widx;
  logic [31:0]        s1_wval;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_calc  <= s0_calc;
      s1_write <= s0_write;
      s1_upper <= s0_upper;
      s1_below <= s0_below;
      s1_above <= s0_above;
      s1_prod  <= 64'(s0_dist) * 64'(index_scale);
      s1_vel   <= s0_vel;
      s1_widx  <= s0_widx;
      s1_wval  <= s0_wval;
    end
  end

  // stage 2: table index and fraction with clamping
  logic               s2_valid, s2_calc, s2_write, s2_upper;
  logic [IDXW-1:0]    s2_whole;
  logic [16:0]        s2_frac;
  logic signed [31:0] s2_vel;
  logic [IDXW-1:0]    s2_widx;
  logic [31:0]        s2_wval;
  logic [IDXW-1:0]    whole_next;
  logic [16:0]        frac_next;

  always_comb begin
    if (s1_below) begin
      whole_next = '0;
      frac_next  = '0;
    end else if (s1_above || s1_prod[63:32] >= 32'(TABLE_SIZE - 1)) begin
      whole_next = IDXW'(TABLE_SIZE - 2);
      frac_next  = ibe_pkg::FRAC_ONE;
    end else begin
      whole_next = s1_prod[32 +: IDXW];
      frac_next  = {1'b0, s1_prod[31:16]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_calc  <= s1_calc;
      s2_write <= s1_write;
      s2_upper <= s1_upper;
      s2_whole <= whole_next;
      s2_frac  <= frac_next;
      s2_vel   <= s1_vel;
      s2_widx  <= s1_widx;
      s2_wval  <= s1_wval;
    end
  end

  // stage 3: table reads and writes, both at this one place in item order
  logic [31:0] lower_mem [TABLE_SIZE];
  logic [31:0] upper_mem [TABLE_SIZE];
  logic [IDXW-1:0] s2_next_idx;

  logic               s3_valid;
  logic [31:0]        s3_lo_a, s3_lo_c, s3_hi_a, s3_hi_c;
  logic [16:0]        s3_frac;
  logic signed [31:0] s3_vel;

  assign s2_next_idx = IDXW'(s2_whole + 1'b1);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s2_valid && s2_write && !s2_upper) begin
        lower_mem[s2_widx] <= s2_wval;
      end
      if (s2_valid && s2_write && s2_upper) begin
        upper_mem[s2_widx] <= s2_wval;
      end
      s3_lo_a <= lower_mem[s2_whole];
      s3_lo_c <= lower_mem[s2_next_idx];
      s3_hi_a <= upper_mem[s2_whole];
      s3_hi_c <= upper_mem[s2_next_idx];
      s3_frac <= s2_frac;
      s3_vel  <= s2_vel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid && s2_calc;
    end
  end

  // stage 4: interpolation products
  logic               s4_valid;
  logic signed [49:0] s4_lo_pa, s4_lo_pc, s4_hi_pa, s4_hi_pc;
  logic signed [31:0] s4_vel;
  logic signed [17:0] w_a, w_c;

  assign w_a = $signed({1'b0, ibe_pkg::FRAC_ONE - s3_frac});
  assign w_c = $signed({1'b0, s3_frac});

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_lo_pa <= $signed(s3_lo_a) * w_a;
      s4_lo_pc <= $signed(s3_lo_c) * w_c;
      s4_hi_pa <= $signed(s3_hi_a) * w_a;
      s4_hi_pc <= $signed(s3_hi_c) * w_c;
      s4_vel   <= s3_vel;
    end
  end

  // stage 5: sum and floor shift
  logic               s5_valid;
  logic signed [31:0] s5_lo, s5_hi, s5_vel;
  logic signed [50:0] lo_sum, hi_sum;

  assign lo_sum = 51'(s4_lo_pa) + 51'(s4_lo_pc);
  assign hi_sum = 51'(s4_hi_pa) + 51'(s4_hi_pc);

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (adv) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_lo  <= lo_sum[47:16];
      s5_hi  <= hi_sum[47:16];
      s5_vel <= s4_vel;
    end
  end

  // stage 6: span and offset of velocity
  logic               s6_valid;
  logic signed [32:0] s6_den, s6_num;
  logic [31:0]        s6_lo, s6_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (adv) begin
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_den <= {s5_hi[31], s5_hi} - {s5_lo[31], s5_lo};
      s6_num <= {s5_vel[31], s5_vel} - {s5_lo[31], s5_lo};
      s6_lo  <= s5_lo;
      s6_hi  <= s5_hi;
    end
  end

  // stage 7: sign fold and saturation, feeds the divider
  logic signed [32:0] den_abs, num_abs;
  div_t               div_in;

  always_comb begin
    if (s6_den < 0) begin
      den_abs = -s6_den;
      num_abs = -s6_num;
    end else begin
      den_abs = s6_den;
      num_abs = s6_num;
    end
    div_in.valid     = s6_valid;
    div_in.lo        = s6_lo;
    div_in.hi        = s6_hi;
    div_in.den       = den_abs[31:0];
    div_in.rem       = num_abs[31:0];
    div_in.q         = '0;
    div_in.fixed     = 1'b1;
    div_in.eff_fixed = '0;
    if (s6_den == 0) begin
      // equal bounds
      div_in.eff_fixed = (s6_num > 0) ? ibe_pkg::FRAC_ONE : '0;
    end else if (num_abs <= 0) begin
      div_in.eff_fixed = '0;
    end else if (num_abs >= den_abs) begin
      div_in.eff_fixed = ibe_pkg::FRAC_ONE;
    end else begin
      div_in.fixed = 1'b0;
    end
  end

  // divider: one restoring step per stage
  div_t div_pipe [DIV_STEPS + 1];

  always_ff @(posedge clk) begin
    if (rst) begin
      div_pipe[0].valid <= 1'b0;
    end else if (adv) begin
      div_pipe[0] <= div_in;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [32:0] r2;
    div_t        step;

    always_comb begin
      step = div_pipe[k];
      r2   = {div_pipe[k].rem, 1'b0};
      if (r2 >= {1'b0, div_pipe[k].den}) begin
        step.rem = 32'(r2 - {1'b0, div_pipe[k].den});
        step.q   = {div_pipe[k].q[14:0], 1'b1};
      end else begin
        step.rem = r2[31:0];
        step.q   = {div_pipe[k].q[14:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        div_pipe[k + 1].valid <= 1'b0;
      end else if (adv) begin
        div_pipe[k + 1] <= step;
      end
    end
  end

  // output register
  div_t last;
  assign last = div_pipe[DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.effort      <= last.fixed ? last.eff_fixed : {1'b0, last.q};
      result.lower_bound <= last.lo;
      result.upper_bound <= last.hi;
    end
  end

  // checks
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (result_valid && result_stall))
    else $error("input stalled with no held result");

  a_effort_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.effort <= ibe_pkg::FRAC_ONE))
    else $error("effort above full scale");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_calc) |-> (32'(s2_whole) <= 32'(TABLE_SIZE - 2)))
    else $error("table index past last pair");

  a_reset_clear: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

endmodule
